// ===== design/sorted_top_n_list_macros.svh =====
// Assertion macros shared by the RTL of the sorted top-N list.
`ifndef SORTED_TOP_N_LIST_MACROS_SVH
`define SORTED_TOP_N_LIST_MACROS_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define SRTN_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
// Condition in one cycle that implies a consequence in the next cycle.
`define SRTN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRTN_ASSERT_ALWAYS(label, cond, msg)
`define SRTN_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/srtn_pkg.sv =====
`default_nettype none

package srtn_pkg;

    localparam int DEFAULT_DEPTH = 16;

    typedef logic signed [31:0] score_t;
    typedef logic [15:0]        tag_t;
    typedef logic [7:0]         pos_t;
    typedef logic [8:0]         fill_t;
    typedef logic [1:0]         status_t;
    typedef logic               op_t;

    localparam op_t OP_INSERT = 1'b0;
    localparam op_t OP_REMOVE = 1'b1;

    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_LOW     = 2'd1;
    localparam status_t ST_BAD_POS = 2'd2;

    typedef struct packed {
        score_t score;
        tag_t   tag;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   en;
        op_t    op;
        entry_t ent;
        pos_t   pos;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/sorted_top_n_list.sv =====
// Output: a result is registered and shows on m_ in the cycle after its acceptance.
// Throughput: one item per cycle unless m_tready stalls a result; every cell
// compares against the new score and shifts toward its neighbor in the same cycle,
// and the output register holds a result while the next item is already accepted.
// Reset (aresetn low, synchronous) empties the list and drops a pending result;
// the input is not ready while reset is held, and cell contents are not cleared.
`default_nettype none

`include "sorted_top_n_list_macros.svh"

module sorted_top_n_list #(
    parameter int DEPTH = srtn_pkg::DEFAULT_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // new_score[31:0], new_tag[47:32], position[55:48]
    input  wire logic        s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // out_score[31:0], out_tag[47:32], fill_count[56:48]
    output logic [1:0]       m_tuser    // status
);
    import srtn_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Accepted item, broadcast to the whole chain of cells.
    logic   acc;
    cmd_t   cmd;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Per-cell signals: g[i] is high where the new score ranks above cell i.
    logic   g     [DEPTH];
    entry_t ent   [DEPTH];
    entry_t hit   [DEPTH];

    entry_t  hit_any;
    logic    ins_ok;
    logic    rm_ok;
    logic    full;

    logic    m_tvalid_reg;
    status_t status_reg;
    status_t status_next;
    entry_t  out_reg;
    entry_t  out_next;
    fill_t   fill_reg;

    // The output register frees up when its result is taken in the same cycle.
    // No item is taken while reset is held, so none can be lost there.
    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign acc      = s_tvalid && s_tready;

    assign cmd.en        = acc;
    assign cmd.op        = s_tuser;
    assign cmd.ent.score = s_tdata[31:0];
    assign cmd.ent.tag   = s_tdata[47:32];
    assign cmd.pos       = s_tdata[55:48];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic   prev_g;
            entry_t prev_ent;
            entry_t next_ent;

            if (gi == 0) begin : g_head
                assign prev_g   = 1'b0;
                assign prev_ent = cmd.ent;
            end else begin : g_mid
                assign prev_g   = g[gi-1];
                assign prev_ent = ent[gi-1];
            end

            // The tail cell refills from itself; its content is then past the fill.
            if (gi == DEPTH - 1) begin : g_tail
                assign next_ent = ent[gi];
            end else begin : g_body
                assign next_ent = ent[gi+1];
            end

            srtn_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk     (aclk),
                .cmd      (cmd),
                .count    (count_reg),
                .prev_g   (prev_g),
                .prev_ent (prev_ent),
                .next_ent (next_ent),
                .g        (g[gi]),
                .ent      (ent[gi]),
                .hit_ent  (hit[gi])
            );
        end
    endgenerate

    // Only the cell at the remove position drives a nonzero entry.
    always_comb begin
        hit_any = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_any = hit_any | hit[i];
        end
    end

    // When the list is not full the tail cell is empty, so its g is high.
    assign full   = count_reg == DEPTH_C;
    assign ins_ok = g[DEPTH-1];
    assign rm_ok  = fill_t'(cmd.pos) < fill_t'(count_reg);

    always_comb begin
        count_next  = count_reg;
        status_next = ST_DONE;
        out_next    = '0;
        case (cmd.op)
            OP_INSERT: begin
                if (!ins_ok) begin
                    status_next = ST_LOW;
                end else if (!full) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (rm_ok) begin
                    out_next   = hit_any;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = ST_BAD_POS;
                end
            end
            default: status_next = ST_DONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (acc) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            status_reg <= status_next;
            out_reg    <= out_next;
            fill_reg   <= fill_t'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, fill_reg, out_reg.tag, out_reg.score};

    // The fill never runs past the number of cells.
    `SRTN_ASSERT_ALWAYS(a_count_bound, count_reg <= DEPTH_C, "entry count exceeds depth")
    // An insert can only be refused when every cell is occupied.
    `SRTN_ASSERT_ALWAYS(a_reject_full, !(acc && cmd.op == OP_INSERT && !ins_ok) || full,
                        "insert rejected while list not full")
    // A pending result always reports the current fill.
    `SRTN_ASSERT_ALWAYS(a_fill_match, !m_tvalid_reg || fill_reg == fill_t'(count_reg),
                        "result fill differs from entry count")
    // Every accepted item leaves a result waiting in the next cycle.
    `SRTN_ASSERT_NEXT(a_result_follows, acc, m_tvalid_reg, "accepted item without result")

endmodule

`default_nettype wire

// ===== design/srtn_cell.sv =====
`default_nettype none

module srtn_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic               aclk,
    input  wire srtn_pkg::cmd_t     cmd,
    input  wire logic [CNT_W-1:0]   count,
    input  wire logic               prev_g,
    input  wire srtn_pkg::entry_t   prev_ent,
    input  wire srtn_pkg::entry_t   next_ent,
    output logic                    g,
    output srtn_pkg::entry_t        ent,
    output srtn_pkg::entry_t        hit_ent
);
    import srtn_pkg::*;

    localparam pos_t           IDX_P = pos_t'(IDX);
    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    entry_t ent_reg;
    entry_t ent_next;
    logic   occ;

    // An empty slot ranks below any new score, so g is monotone along the chain.
    assign occ = count > IDX_C;
    assign g   = !occ || (cmd.ent.score > ent_reg.score);

    always_comb begin
        ent_next = ent_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (g) begin
                    ent_next = prev_g ? prev_ent : cmd.ent;
                end
            end
            OP_REMOVE: begin
                if (cmd.pos <= IDX_P) begin
                    ent_next = next_ent;
                end
            end
            default: ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            ent_reg <= ent_next;
        end
    end

    assign ent     = ent_reg;
    assign hit_ent = (cmd.pos == IDX_P) ? ent_reg : '0;

endmodule

`default_nettype wire
